[hw/rtl/assert_macros.svh]
// Assertion macros used by the pru_replicate RTL module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

[hw/rtl/pru_pkg.sv]
// Types, constants and helper functions of the pixel replication upscaler
package pru_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int MAX_SCALE  = 8;

  localparam int DIM_W   = 12;
  localparam int SCALE_W = 4;
  localparam int CFG_W   = 12;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int COPY_W  = $clog2(MAX_SCALE);

  typedef enum logic [1:0] {
    REG_IN_WIDTH  = 2'd0,
    REG_IN_HEIGHT = 2'd1,
    REG_SCALE     = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       last_copy;
    logic       row_end;
    logic [1:0] pad_bytes;
    logic       took_pixel;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [SCALE_W-1:0] scale;
    logic [1:0]         pad;
  } geom_t;

  typedef struct packed {
    in_item_t pixel;
    logic     took;
    logic     col_last;
    logic     copy_last;
    logic     row_last;
  } stage_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [SCALE_W-1:0] clamp_scale(input logic [SCALE_W-1:0] v);
    logic [SCALE_W-1:0] r;
    if (v < SCALE_W'(2)) begin
      r = SCALE_W'(2);
    end else if (v > SCALE_W'(MAX_SCALE)) begin
      r = SCALE_W'(MAX_SCALE);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[hw/rtl/pru_fetch.sv]
// Position counters, line store and input stage register
module pru_fetch
  import pru_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  geom_t    geom,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     s1_valid,
  output stage_t   s1_item,
  input  logic     s1_take
);

  logic [23:0]      mem [MAX_WIDTH];
  logic [23:0]      rd_r;
  logic [COL_W-1:0] col_r, col_nxt, col_eff;
  logic [COPY_W-1:0] copy_r, copy_nxt, copy_eff;
  logic [ROW_W-1:0] row_r, row_nxt, row_eff;
  logic             s1_valid_r, s1_valid_nxt;
  stage_t           s1_r;
  logic             in_fire, took, col_last, copy_last, row_last;

  assign in_ready = !s1_valid_r || s1_take;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    col_eff   = ({1'b0, col_r} >= geom.width) ? '0 : col_r;
    copy_eff  = ({1'b0, copy_r} >= geom.scale) ? '0 : copy_r;
    row_eff   = ({1'b0, row_r} >= geom.height) ? '0 : row_r;
    took      = (copy_eff == '0);
    col_last  = ({1'b0, col_eff} == (geom.width - DIM_W'(1)));
    copy_last = ({1'b0, copy_eff} == (geom.scale - SCALE_W'(1)));
    row_last  = ({1'b0, row_eff} == (geom.height - DIM_W'(1)));
  end

  always_comb begin
    col_nxt  = col_r;
    copy_nxt = copy_r;
    row_nxt  = row_r;
    if (in_fire) begin
      col_nxt  = col_eff + COL_W'(1);
      copy_nxt = copy_eff;
      row_nxt  = row_eff;
      if (col_last) begin
        col_nxt = '0;
        if (copy_last) begin
          copy_nxt = '0;
          row_nxt  = row_last ? '0 : row_eff + ROW_W'(1);
        end else begin
          copy_nxt = copy_eff + COPY_W'(1);
        end
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      copy_r     <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      copy_r     <= copy_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r.pixel     <= in_data;
      s1_r.took      <= took;
      s1_r.col_last  <= col_last;
      s1_r.copy_last <= copy_last;
      s1_r.row_last  <= row_last;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && took) begin
      mem[col_eff] <= in_data;
    end
    if (in_fire && !took) begin
      rd_r <= mem[col_eff];
    end
  end

  always_comb begin
    s1_item = s1_r;
    if (!s1_r.took) begin
      s1_item.pixel = rd_r;
    end
  end

  assign s1_valid = s1_valid_r;

endmodule

[hw/rtl/pru_replicate.sv]
// Copy emitter and output register
`include "assert_macros.svh"
module pru_replicate
  import pru_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  geom_t     geom,
  input  logic      s1_valid,
  input  stage_t    s1_item,
  output logic      s1_take,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic              rep_valid_r, rep_valid_nxt;
  logic [COPY_W-1:0] k_r, k_nxt, s_m1;
  stage_t            item_r;
  logic              out_fire, last, rend, fend;

  assign s_m1     = COPY_W'(geom.scale - SCALE_W'(1));
  assign last     = (k_r == s_m1);
  assign out_fire = rep_valid_r && out_ready;
  assign s1_take  = s1_valid && (!rep_valid_r || (out_fire && last));

  always_comb begin
    rep_valid_nxt = rep_valid_r;
    k_nxt         = k_r;
    if (s1_take) begin
      rep_valid_nxt = 1'b1;
      k_nxt         = '0;
    end else if (out_fire && last) begin
      rep_valid_nxt = 1'b0;
    end else if (out_fire) begin
      k_nxt = k_r + COPY_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      rep_valid_r <= rep_valid_nxt;
      k_r         <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      item_r <= s1_item;
    end
  end

  assign rend = last && item_r.col_last;
  assign fend = rend && item_r.copy_last && item_r.row_last;

  always_comb begin
    out_data.out_blue   = item_r.pixel.in_blue;
    out_data.out_green  = item_r.pixel.in_green;
    out_data.out_red    = item_r.pixel.in_red;
    out_data.last_copy  = last;
    out_data.row_end    = rend;
    out_data.pad_bytes  = rend ? geom.pad : 2'd0;
    out_data.took_pixel = item_r.took;
    out_data.frame_end  = fend;
  end

  assign out_valid = rep_valid_r;

  `ASSERT_NEVER(a_copy_range, clk, rst_n, rep_valid_r && ({1'b0, k_r} >= geom.scale), "copy index beyond scale")
  `ASSERT_CLK(a_fend_row, clk, rst_n, (rep_valid_r && fend) |-> (rend && last), "frame end off row end")
  `ASSERT_CLK(a_copy_hold, clk, rst_n, (out_fire && !last) |=> (rep_valid_r && $stable(item_r)), "copy item changed mid run")
  `ASSERT_NEVER(a_pad_row, clk, rst_n, rep_valid_r && !rend && (out_data.pad_bytes != 2'd0), "pad off row end")

endmodule

[hw/rtl/pixel_replication_upscaler_top.sv]
// Top level of the pixel replication upscaler: configuration registers and stages
// Each item passes the input stage register, then the output register offers copies.
// Throughput: one output pixel per cycle while out_ready is high and items arrive.
// The copy counter of the output stage paces the input; the line store is
// one read or one write per item. Reset clears counters and handshake state,
// restores width 1, height 1, scale 2; the line store is not cleared.
module pixel_replication_upscaler_top
  import pru_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  logic [DIM_W-1:0]   in_width_r, in_height_r;
  logic [SCALE_W-1:0] scale_r;
  geom_t              geom;
  logic [3:0]         wsp;
  logic               s1_valid, s1_take;
  stage_t             s1_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_width_r  <= DIM_W'(1);
      in_height_r <= DIM_W'(1);
      scale_r     <= SCALE_W'(2);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_IN_WIDTH:  in_width_r  <= cfg_wdata[DIM_W-1:0];
        REG_IN_HEIGHT: in_height_r <= cfg_wdata[DIM_W-1:0];
        REG_SCALE:     scale_r     <= cfg_wdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    geom.width  = clamp_dim(in_width_r, DIM_W'(MAX_WIDTH));
    geom.height = clamp_dim(in_height_r, DIM_W'(MAX_HEIGHT));
    geom.scale  = clamp_scale(scale_r);
    wsp         = {2'b00, geom.width[1:0]} * {2'b00, geom.scale[1:0]};
    geom.pad    = wsp[1:0];
  end

  pru_fetch u_fetch (
    .clk      (clk),
    .rst_n    (rst_n),
    .geom     (geom),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .s1_take  (s1_take)
  );

  pru_replicate u_replicate (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .s1_take   (s1_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
